// ===== rtl/pfe_pkg.sv =====
// shared constants, codes and port structs of the postfix evaluator
`timescale 1ns / 1ps
package pfe_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int NUM_VARS    = 8;
	localparam int VAR_IDX_W   = $clog2(NUM_VARS);
	localparam int CFG_IDX_W   = 4;
	localparam int SYM_W       = 8;
	localparam int ERR_W       = 3;
	localparam int DIV_CNT_W   = $clog2(DATA_W);
	localparam int OUT_W       = ((DATA_W + ERR_W + 7) / 8) * 8;

	localparam logic [SYM_W-1:0] SYM_ADD       = 8'h2B;
	localparam logic [SYM_W-1:0] SYM_SUB       = 8'h2D;
	localparam logic [SYM_W-1:0] SYM_MUL       = 8'h2A;
	localparam logic [SYM_W-1:0] SYM_DIV       = 8'h2F;
	localparam logic [SYM_W-1:0] SYM_VAR_FIRST = 8'h41;
	localparam logic [SYM_W-1:0] SYM_VAR_LAST  = 8'h48;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE,
		ERR_UNDERFLOW,
		ERR_OVERFLOW,
		ERR_DIVZERO,
		ERR_UNKNOWN,
		ERR_LEFTOVER
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                en;
		logic [STACK_AW-1:0] addr;
		logic [DATA_W-1:0]   data;
	} ram_wr_t;

	typedef struct packed {
		logic                en;
		logic [STACK_AW-1:0] addr;
	} ram_rd_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/pfe_stack_ram.sv =====
// operand stack memory, one write and one registered read port
`timescale 1ns / 1ps
module pfe_stack_ram import pfe_pkg::*; (
	input  logic              clk,
	input  ram_wr_t           wr,
	input  ram_rd_t           rd,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata <= mem[rd.addr];
		end
	end

endmodule

// ===== rtl/pfe_div.sv =====
// iterative signed divider, one quotient bit per cycle, truncating
`timescale 1ns / 1ps
module pfe_div import pfe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    quo_q;
	logic [DATA_W-1:0]    div_q;
	logic [DATA_W-1:0]    mag_l;
	logic [DATA_W-1:0]    mag_r;
	logic [DATA_W:0]      rem_sh;
	logic [DATA_W:0]      diff;

	assign mag_l  = req.dividend[DATA_W-1] ? (DATA_W'(0) - req.dividend) : req.dividend;
	assign mag_r  = req.divisor[DATA_W-1] ? (DATA_W'(0) - req.divisor) : req.divisor;
	assign rem_sh = {rem_q, quo_q[DATA_W-1]};
	assign diff   = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DATA_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - DIV_CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= mag_l;
			div_q <= mag_r;
			neg_q <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
		end else if (busy_q) begin
			// restoring step: keep the difference when it did not borrow
			if (!diff[DATA_W]) begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule

// ===== rtl/postfix_expression_evaluator.sv =====
// postfix evaluator: one symbol per request, stack top in a register, rest in memory
// order: variable push loads tos; add/sub/mul read stack memory, then alu writes tos;
// divide reads, runs the 32 divider steps, writes back; the last symbol then loads the
// result register in the finish state. one symbol in flight at a time.
// reset clears the control state, the stack count, the error and variables A to H;
// the stack memory is not cleared
`timescale 1ns / 1ps
module postfix_expression_evaluator import pfe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [SYM_W-1:0]     s_tdata,   // symbol
	input  logic                 s_tlast,   // last_symbol
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // value [31:0], error_code [34:32], zero fill
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	state_t               state_q, state_d;
	err_t                 err_q, err_d;
	logic [CNT_W-1:0]     count_q;
	logic [DATA_W-1:0]    tos_q;
	logic [SYM_W-1:0]     sym_q;
	logic                 last_q;
	logic [DATA_W-1:0]    vars_q [NUM_VARS];
	logic                 m_valid_q;
	logic [DATA_W-1:0]    out_value_q;
	err_t                 out_err_q;

	logic                 s_accept;
	logic                 out_free;
	logic                 in_is_var;
	logic                 in_is_op;
	logic                 stack_full;
	logic                 stack_few;
	logic [SYM_W-1:0]     var_off;
	logic [CNT_W-1:0]     cnt_m1;
	logic [CNT_W-1:0]     cnt_m2;
	logic [DATA_W-1:0]    left_op;
	logic [DATA_W-1:0]    prod;
	logic [DATA_W-1:0]    alu_res;
	logic [DATA_W-1:0]    fin_value;
	err_t                 fin_err;

	logic                 push, rd_req, err_set, alu_wr, div_start, div_wr, finish;

	ram_wr_t              ram_wr;
	ram_rd_t              ram_rd;
	div_req_t             div_req;
	div_rsp_t             div_rsp;

	assign s_accept   = s_tvalid && s_tready;
	assign out_free   = !m_valid_q || m_tready;
	assign in_is_var  = s_tdata inside {[SYM_VAR_FIRST:SYM_VAR_LAST]};
	assign in_is_op   = s_tdata inside {SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV};
	assign stack_full = (count_q == CNT_W'(STACK_DEPTH));
	assign stack_few  = (count_q < CNT_W'(2));
	assign var_off    = s_tdata - SYM_VAR_FIRST;
	assign cnt_m1     = count_q - CNT_W'(1);
	assign cnt_m2     = count_q - CNT_W'(2);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					if (err_q == ERR_NONE && in_is_op && !stack_few) begin
						state_d = ST_READ;
					end else if (s_tlast) begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_READ: begin
				if (sym_q == SYM_DIV && tos_q != '0) begin
					state_d = ST_DIV;
				end else begin
					state_d = last_q ? ST_FINISH : ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = last_q ? ST_FINISH : ST_IDLE;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready  = 1'b0;
		push      = 1'b0;
		rd_req    = 1'b0;
		err_set   = 1'b0;
		err_d     = ERR_NONE;
		alu_wr    = 1'b0;
		div_start = 1'b0;
		div_wr    = 1'b0;
		finish    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				// symbols after the first error are dropped until the last one
				if (s_accept && err_q == ERR_NONE) begin
					if (in_is_var) begin
						if (stack_full) begin
							err_set = 1'b1;
							err_d   = ERR_OVERFLOW;
						end else begin
							push = 1'b1;
						end
					end else if (in_is_op) begin
						if (stack_few) begin
							err_set = 1'b1;
							err_d   = ERR_UNDERFLOW;
						end else begin
							rd_req = 1'b1;
						end
					end else begin
						err_set = 1'b1;
						err_d   = ERR_UNKNOWN;
					end
				end
			end
			ST_READ: begin
				if (sym_q == SYM_DIV) begin
					if (tos_q == '0) begin
						err_set = 1'b1;
						err_d   = ERR_DIVZERO;
					end else begin
						div_start = 1'b1;
					end
				end else begin
					alu_wr = 1'b1;
				end
			end
			ST_DIV: begin
				div_wr = div_rsp.done;
			end
			ST_FINISH: begin
				finish = out_free;
			end
			default: ;
		endcase
	end

	// the top of stack lives in tos_q, the entries below it in memory
	assign ram_wr.en   = push && (count_q != '0);
	assign ram_wr.addr = cnt_m1[STACK_AW-1:0];
	assign ram_wr.data = tos_q;
	assign ram_rd.en   = rd_req;
	assign ram_rd.addr = cnt_m2[STACK_AW-1:0];

	pfe_stack_ram u_ram (
		.clk   (clk),
		.wr    (ram_wr),
		.rd    (ram_rd),
		.rdata (left_op)
	);

	assign div_req.start    = div_start;
	assign div_req.dividend = left_op;
	assign div_req.divisor  = tos_q;

	pfe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign prod = left_op * tos_q;

	always_comb begin
		case (sym_q)
			SYM_SUB: alu_res = left_op - tos_q;
			SYM_MUL: alu_res = prod;
			default: alu_res = left_op + tos_q;
		endcase
	end

	always_comb begin
		fin_value = '0;
		fin_err   = err_q;
		if (err_q == ERR_NONE) begin
			if (count_q == CNT_W'(1)) begin
				fin_value = tos_q;
			end else if (count_q == '0) begin
				fin_err = ERR_UNDERFLOW;
			end else begin
				fin_err = ERR_LEFTOVER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			err_q     <= ERR_NONE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				err_q <= ERR_NONE;
			end else if (err_set) begin
				err_q <= err_d;
			end
			if (finish) begin
				count_q <= '0;
			end else if (push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (alu_wr || div_wr) begin
				count_q <= cnt_m1;
			end
			if (finish) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VARS; i++) begin
				vars_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready && cfg_index < CFG_IDX_W'(NUM_VARS)) begin
			vars_q[cfg_index[VAR_IDX_W-1:0]] <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			sym_q  <= s_tdata;
			last_q <= s_tlast;
		end
		if (push) begin
			tos_q <= vars_q[var_off[VAR_IDX_W-1:0]];
		end else if (alu_wr) begin
			tos_q <= alu_res;
		end else if (div_wr) begin
			tos_q <= div_rsp.quotient;
		end
		if (finish) begin
			out_value_q <= fin_value;
			out_err_q   <= fin_err;
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = {(OUT_W - DATA_W - ERR_W)'(0), out_err_q, out_value_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_sticky_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ERR_NONE) |-> (!push && !rd_req && !div_start))
		else $error("stack touched after an error");

	a_ram_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_wr.en && ram_rd.en))
		else $error("stack read and write in one cycle");

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (count_q == '0 && err_q == ERR_NONE && m_valid_q))
		else $error("end of expression did not clear the stack");

endmodule
